### rtl/core/nsp_pkg.sv
package nsp_pkg;

    localparam int MAX_FIELDS = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_RMC  = 2'd1;
    localparam logic [1:0] KIND_GGA  = 2'd2;
    localparam logic [1:0] KIND_GSA  = 2'd3;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    localparam logic [23:0] TYPE_RMC = 24'h524D43;
    localparam logic [23:0] TYPE_GGA = 24'h474741;
    localparam logic [23:0] TYPE_GSA = 24'h475341;

    localparam logic [16:0] INT_SAT     = 17'd131071;
    localparam logic [29:0] LAT_LIMIT   = 30'd900000000;
    localparam logic [30:0] LON_LIMIT   = 31'd1800000000;
    localparam logic [24:0] SPEED_LIMIT = 25'd20000000;
    localparam logic [13:0] DOP_LIMIT   = 14'd9999;
    localparam logic [26:0] SPEED_CLIP_FROM = 27'd10799136;

    typedef struct packed {
        logic        has_field;
        logic        last;
        logic        ok;
        logic        rmc_status;
        logic [1:0]  hemi;
        logic [1:0]  kind;
        logic [4:0]  field;
        logic [16:0] int_part;
        logic [6:0]  f2;
        logic [9:0]  f3;
        logic [16:0] f5;
    } t_entry;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        else v = 5'd16;
        return v;
    endfunction

endpackage

### rtl/core/nsp_fifo.sv
module nsp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nsp_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output nsp_pkg::t_entry o_data
);
    import nsp_pkg::*;

    t_entry            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               push, pop;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
        if (push) r_mem[r_wp] <= i_data;
    end

endmodule

### rtl/core/nsp_front.sv
module nsp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_char_code,
    input  logic            i_last_char,
    output logic            o_push,
    output nsp_pkg::t_entry o_entry
);
    import nsp_pkg::*;

    typedef enum logic [2:0] {PH_START, PH_DATA, PH_HEX1, PH_HEX2, PH_OK, PH_FAIL} t_phase;
    typedef enum logic [1:0] {NUM_INT, NUM_FRAC, NUM_STOP} t_num;

    t_phase      r_phase, n_phase;
    t_num        r_num, n_num;
    logic [7:0]  r_xor, n_xor;
    logic [3:0]  r_rx_hi, n_rx_hi;
    logic [6:0]  r_pos, n_pos;
    logic [4:0]  r_field, n_field;
    logic [15:0] r_letters, n_letters;
    logic [1:0]  r_kind, n_kind;
    logic [16:0] r_int, n_int;
    logic [6:0]  r_f2, n_f2;
    logic [9:0]  r_f3, n_f3;
    logic [16:0] r_f5, n_f5;
    logic [2:0]  r_fd, n_fd;
    logic        r_at_start, n_at_start;
    logic        r_status, n_status;
    logic [1:0]  r_hemi, n_hemi;

    logic        fin;
    logic        digit;
    logic [3:0]  d;
    logic [4:0]  hv;
    logic [20:0] int_tmp;
    logic [23:0] letters3;

    always_comb begin
        n_phase = r_phase;  n_num = r_num;   n_xor = r_xor;   n_rx_hi = r_rx_hi;
        n_pos = r_pos;      n_field = r_field; n_letters = r_letters; n_kind = r_kind;
        n_int = r_int;      n_f2 = r_f2;     n_f3 = r_f3;     n_f5 = r_f5;
        n_fd = r_fd;        n_at_start = r_at_start; n_status = r_status; n_hemi = r_hemi;
        fin      = 1'b0;
        digit    = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        d        = 4'(i_char_code - CH_ZERO);
        hv       = hex_value(i_char_code);
        int_tmp  = 21'(r_int) * 21'd10 + 21'(d);
        letters3 = {r_letters, i_char_code};

        unique case (r_phase)
            PH_START: n_phase = (i_char_code == CH_DOLLAR) ? PH_DATA : PH_FAIL;
            PH_DATA: begin
                if (i_char_code == CH_STAR) begin
                    if (r_pos == 7'd1) n_phase = PH_FAIL;
                    else begin
                        fin     = 1'b1;
                        n_phase = PH_HEX1;
                    end
                end else begin
                    n_xor = r_xor ^ i_char_code;
                    if (r_field == '0 && r_pos >= 7'd3 && r_pos <= 7'd5) begin
                        n_letters = letters3[15:0];
                        if (r_pos == 7'd5) begin
                            if (letters3 == TYPE_RMC) n_kind = KIND_RMC;
                            else if (letters3 == TYPE_GGA) n_kind = KIND_GGA;
                            else if (letters3 == TYPE_GSA) n_kind = KIND_GSA;
                        end
                    end
                    if (i_char_code == CH_COMMA && 6'(r_field) + 6'd1 < 6'(MAX_FIELDS)) begin
                        fin        = 1'b1;
                        n_field    = r_field + 5'd1;
                        n_int      = '0;
                        n_f2       = '0;
                        n_f3       = '0;
                        n_f5       = '0;
                        n_fd       = '0;
                        n_num      = NUM_INT;
                        n_at_start = 1'b1;
                    end else begin
                        if (r_at_start && r_kind == KIND_RMC) begin
                            if (r_field == 5'd2) n_status = (i_char_code == CH_A);
                            if (r_field == 5'd4 && i_char_code == CH_S) n_hemi[0] = 1'b1;
                            if (r_field == 5'd6 && i_char_code == CH_W) n_hemi[1] = 1'b1;
                        end
                        n_at_start = 1'b0;
                        case (r_num)
                            NUM_INT: begin
                                if (digit)
                                    n_int = (int_tmp > 21'(INT_SAT)) ? INT_SAT : int_tmp[16:0];
                                else if (i_char_code == CH_DOT) n_num = NUM_FRAC;
                                else n_num = NUM_STOP;
                            end
                            NUM_FRAC: begin
                                if (!digit) n_num = NUM_STOP;
                                else if (r_fd < 3'd5) begin
                                    n_fd = r_fd + 3'd1;
                                    case (r_fd)
                                        3'd0: begin
                                            n_f5 = r_f5 + 17'(d) * 17'd10000;
                                            n_f3 = r_f3 + 10'(d) * 10'd100;
                                            n_f2 = r_f2 + 7'(d) * 7'd10;
                                        end
                                        3'd1: begin
                                            n_f5 = r_f5 + 17'(d) * 17'd1000;
                                            n_f3 = r_f3 + 10'(d) * 10'd10;
                                            n_f2 = r_f2 + 7'(d);
                                        end
                                        3'd2: begin
                                            n_f5 = r_f5 + 17'(d) * 17'd100;
                                            n_f3 = r_f3 + 10'(d);
                                        end
                                        3'd3: n_f5 = r_f5 + 17'(d) * 17'd10;
                                        default: n_f5 = r_f5 + 17'(d);
                                    endcase
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            PH_HEX1: begin
                if (hv[4]) n_phase = PH_FAIL;
                else begin
                    n_rx_hi = hv[3:0];
                    n_phase = PH_HEX2;
                end
            end
            PH_HEX2: begin
                if (hv[4]) n_phase = PH_FAIL;
                else n_phase = ({r_rx_hi, hv[3:0]} == r_xor) ? PH_OK : PH_FAIL;
            end
            default: ;
        endcase
        if (r_pos != 7'd127) n_pos = r_pos + 7'd1;
    end

    always_comb begin
        o_push             = i_accept && (fin || i_last_char);
        o_entry.has_field  = fin;
        o_entry.last       = i_last_char;
        o_entry.ok         = (n_phase == PH_OK) && (n_kind != KIND_NONE);
        o_entry.rmc_status = n_status;
        o_entry.hemi       = n_hemi;
        o_entry.kind       = n_kind;
        o_entry.field      = r_field;
        o_entry.int_part   = r_int;
        o_entry.f2         = r_f2;
        o_entry.f3         = r_f3;
        o_entry.f5         = r_f5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_char)) begin
            r_phase <= PH_START;  r_num <= NUM_INT;  r_xor <= '0;  r_rx_hi <= '0;
            r_pos <= '0;  r_field <= '0;  r_letters <= '0;  r_kind <= KIND_NONE;
            r_int <= '0;  r_f2 <= '0;  r_f3 <= '0;  r_f5 <= '0;  r_fd <= '0;
            r_at_start <= 1'b1;  r_status <= 1'b0;  r_hemi <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;  r_num <= n_num;  r_xor <= n_xor;  r_rx_hi <= n_rx_hi;
            r_pos <= n_pos;  r_field <= n_field;  r_letters <= n_letters;  r_kind <= n_kind;
            r_int <= n_int;  r_f2 <= n_f2;  r_f3 <= n_f3;  r_f5 <= n_f5;  r_fd <= n_fd;
            r_at_start <= n_at_start;  r_status <= n_status;  r_hemi <= n_hemi;
        end
    end

endmodule

### rtl/core/nsp_back.sv
module nsp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  nsp_pkg::t_entry    i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_parse_ok,
    output logic [1:0]         o_sentence_kind,
    output logic               o_fix_valid,
    output logic signed [30:0] o_latitude,
    output logic signed [31:0] o_longitude,
    output logic [24:0]        o_speed_mkmh,
    output logic [3:0]         o_fix_quality,
    output logic [7:0]         o_satellites,
    output logic [13:0]        o_hdop,
    output logic [13:0]        o_pdop,
    output logic [13:0]        o_vdop
);
    import nsp_pkg::*;

    logic   en;
    logic   r_v1, r_v2, r_v3, r_v4;
    t_entry r_e1, r_e2, r_e3, r_e4;

    logic [29:0] r_q1;
    logic [26:0] r_spd1;
    logic [23:0] r_dop1;
    logic [10:0] r_deg2;
    logic [6:0]  r_rem2;
    logic        r_big2;
    logic [31:0] r_y2;
    logic [13:0] r_dop2, r_dop3, r_dop4;
    logic [25:0] r_z3;
    logic [33:0] r_degm3, r_degm4;
    logic [24:0] r_sp3, r_sp4;
    logic [23:0] r_zp4;

    logic [29:0] r_lat, n_lat;
    logic [30:0] r_lon, n_lon;
    logic [24:0] r_spd, n_spd;
    logic [3:0]  r_fq, n_fq;
    logic [7:0]  r_sat, n_sat;
    logic [13:0] r_hdop, n_hdop, r_pdop, n_pdop, r_vdop, n_vdop;
    logic        r_gsa, n_gsa;

    logic        r_ok;
    logic [1:0]  r_kind;
    logic        r_fix;
    logic [30:0] r_lat_o;
    logic [31:0] r_lon_o;
    logic [24:0] r_spd_o;
    logic [3:0]  r_fq_o;
    logic [7:0]  r_sat_o;
    logic [13:0] r_hdop_o, r_pdop_o, r_vdop_o;
    logic        r_out_valid;

    logic [34:0] mag;
    logic [29:0] lat_c;
    logic [30:0] lon_c;
    logic        emit;

    assign en    = !r_out_valid || i_out_ready;
    assign o_pop = en && i_head_valid;
    assign emit  = r_v4 && r_e4.last;

    always_comb begin
        mag   = 35'(r_degm4) + 35'(r_zp4);
        lat_c = (mag > 35'(LAT_LIMIT)) ? LAT_LIMIT : mag[29:0];
        lon_c = (mag > 35'(LON_LIMIT)) ? LON_LIMIT : mag[30:0];
        n_lat = r_lat;  n_lon = r_lon;  n_spd = r_spd;  n_fq = r_fq;  n_sat = r_sat;
        n_hdop = r_hdop;  n_pdop = r_pdop;  n_vdop = r_vdop;  n_gsa = r_gsa;
        if (r_v4 && r_e4.has_field) begin
            case (r_e4.kind)
                KIND_RMC: begin
                    if (r_e4.field == 5'd3) n_lat = lat_c;
                    if (r_e4.field == 5'd5) n_lon = lon_c;
                    if (r_e4.field == 5'd7) n_spd = r_sp4;
                end
                KIND_GGA: begin
                    if (r_e4.field == 5'd6)
                        n_fq = (r_e4.int_part > 17'd15) ? 4'd15 : r_e4.int_part[3:0];
                    if (r_e4.field == 5'd7)
                        n_sat = (r_e4.int_part > 17'd255) ? 8'd255 : r_e4.int_part[7:0];
                    if (r_e4.field == 5'd8) n_hdop = r_dop4;
                end
                KIND_GSA: begin
                    if (r_e4.field == 5'd2)  n_gsa = (r_e4.int_part >= 17'd2);
                    if (r_e4.field == 5'd15) n_pdop = r_dop4;
                    if (r_e4.field == 5'd16) n_hdop = r_dop4;
                    if (r_e4.field == 5'd17) n_vdop = r_dop4;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;  r_v2 <= 1'b0;  r_v3 <= 1'b0;  r_v4 <= 1'b0;
            r_out_valid <= 1'b0;
            r_lat <= '0;  r_lon <= '0;  r_spd <= '0;  r_fq <= '0;  r_sat <= '0;
            r_hdop <= '0;  r_pdop <= '0;  r_vdop <= '0;  r_gsa <= 1'b0;
        end else if (en) begin
            r_v1 <= i_head_valid;  r_v2 <= r_v1;  r_v3 <= r_v2;  r_v4 <= r_v3;
            r_out_valid <= emit;
            if (emit) begin
                r_lat <= '0;  r_lon <= '0;  r_spd <= '0;  r_fq <= '0;  r_sat <= '0;
                r_hdop <= '0;  r_pdop <= '0;  r_vdop <= '0;  r_gsa <= 1'b0;
            end else begin
                r_lat <= n_lat;  r_lon <= n_lon;  r_spd <= n_spd;  r_fq <= n_fq;
                r_sat <= n_sat;  r_hdop <= n_hdop;  r_pdop <= n_pdop;  r_vdop <= n_vdop;
                r_gsa <= n_gsa;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // int/100 by reciprocal, exact for int_part up to 43698
            r_e1   <= i_head;
            r_q1   <= 30'(i_head.int_part) * 30'd5243;
            r_spd1 <= 27'(i_head.int_part) * 27'd1000 + 27'(i_head.f3);
            r_dop1 <= 24'(i_head.int_part) * 24'd100 + 24'(i_head.f2);

            r_e2   <= r_e1;
            r_deg2 <= r_q1[29:19];
            r_rem2 <= 7'(r_e1.int_part - 17'(r_q1[29:19]) * 17'd100);
            r_big2 <= (r_spd1 >= SPEED_CLIP_FROM);
            r_y2   <= 32'((33'(r_spd1[23:0]) * 33'd463 + 33'd125) >> 1);
            r_dop2 <= (r_dop1 > 24'(DOP_LIMIT)) ? DOP_LIMIT : r_dop1[13:0];

            // minutes scaled for the divide by 60 done as a divide by 3
            r_e3    <= r_e2;
            r_z3    <= 26'((27'(r_rem2) * 27'd1000000 + 27'(r_e2.f5) * 27'd10 + 27'd3) >> 1);
            r_degm3 <= 34'(r_deg2) * 34'd10000000;
            r_sp3   <= r_big2 ? SPEED_LIMIT
                              : 25'((65'(r_y2) * 65'd4398046512) >> 39);
            r_dop3  <= r_dop2;

            r_e4    <= r_e3;
            r_zp4   <= 24'((52'(r_z3) * 52'd44739243) >> 27);
            r_degm4 <= r_degm3;
            r_sp4   <= r_sp3;
            r_dop4  <= r_dop3;

            if (emit) begin
                r_ok <= r_e4.ok;  r_kind <= '0;  r_fix <= 1'b0;
                r_lat_o <= '0;  r_lon_o <= '0;  r_spd_o <= '0;  r_fq_o <= '0;
                r_sat_o <= '0;  r_hdop_o <= '0;  r_pdop_o <= '0;  r_vdop_o <= '0;
                if (r_e4.ok) begin
                    r_kind <= r_e4.kind;
                    case (r_e4.kind)
                        KIND_RMC: begin
                            r_fix <= r_e4.rmc_status;
                            if (r_e4.rmc_status) begin
                                r_lat_o <= r_e4.hemi[0] ? 31'd0 - {1'b0, n_lat}
                                                        : {1'b0, n_lat};
                                r_lon_o <= r_e4.hemi[1] ? 32'd0 - {1'b0, n_lon}
                                                        : {1'b0, n_lon};
                                r_spd_o <= n_spd;
                            end
                        end
                        KIND_GGA: begin
                            r_fix    <= (n_fq != 4'd0);
                            r_fq_o   <= n_fq;
                            r_sat_o  <= n_sat;
                            r_hdop_o <= n_hdop;
                        end
                        default: begin
                            r_fix    <= n_gsa;
                            r_hdop_o <= n_hdop;
                            r_pdop_o <= n_pdop;
                            r_vdop_o <= n_vdop;
                        end
                    endcase
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_parse_ok      = r_ok;
    assign o_sentence_kind = r_kind;
    assign o_fix_valid     = r_fix;
    assign o_latitude      = r_lat_o;
    assign o_longitude     = r_lon_o;
    assign o_speed_mkmh    = r_spd_o;
    assign o_fix_quality   = r_fq_o;
    assign o_satellites    = r_sat_o;
    assign o_hdop          = r_hdop_o;
    assign o_pdop          = r_pdop_o;
    assign o_vdop          = r_vdop_o;

endmodule

### rtl/core/nmea_sentence_parser.sv
// nmea sentence parser
// input channel: one character per beat (i_char_code, i_last_char) on
// i_in_valid / o_in_ready; i_last_char marks the final character of a line
// output channel: one result beat per line on o_out_valid / i_out_ready,
// carrying checksum status, sentence kind and the decoded rmc, gga or gsa values
// throughput: one character per cycle while o_in_ready is high; the front
// end scans characters and hands finished fields to a four-entry queue; the
// back end converts them in a five-stage arithmetic pipeline (multiplier bound)
// result path: the entry of the last character is written to the queue, then
// passes the back stages r_e1 to r_e4 and the registered result outputs
// receiver stall: the back pipeline holds, the queue fills, and o_in_ready
// drops once the queue is full; nothing is lost
// reset: synchronous active-low i_rst_n returns the line scanner to waiting
// for a dollar sign and empties the queue and pipeline; no clearing pass
module nmea_sentence_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_last_char,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_parse_ok,
    output logic [1:0]         o_sentence_kind,
    output logic               o_fix_valid,
    output logic signed [30:0] o_latitude,
    output logic signed [31:0] o_longitude,
    output logic [24:0]        o_speed_mkmh,
    output logic [3:0]         o_fix_quality,
    output logic [7:0]         o_satellites,
    output logic [13:0]        o_hdop,
    output logic [13:0]        o_pdop,
    output logic [13:0]        o_vdop
);
    import nsp_pkg::*;

    logic   accept, push, full, head_valid, pop;
    t_entry entry, head;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    nsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_push      (push),
        .o_entry     (entry)
    );

    nsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head)
    );

    nsp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_parse_ok      (o_parse_ok),
        .o_sentence_kind (o_sentence_kind),
        .o_fix_valid     (o_fix_valid),
        .o_latitude      (o_latitude),
        .o_longitude     (o_longitude),
        .o_speed_mkmh    (o_speed_mkmh),
        .o_fix_quality   (o_fix_quality),
        .o_satellites    (o_satellites),
        .o_hdop          (o_hdop),
        .o_pdop          (o_pdop),
        .o_vdop          (o_vdop)
    );

endmodule
